/* rtl/tslf_pkg.sv */
// tslf_pkg: shared types and constants for the text stream line formatter
// no dependencies

package tslf_pkg;

  localparam int DEF_NUMBER_DIGITS = 6;
  localparam int DEF_QUEUE_DEPTH   = 4;

  localparam int CFG_AW = 5;

  localparam logic [2:0] REG_SHOW_NONPRINTING = 3'd0;
  localparam logic [2:0] REG_NUMBER_NONBLANK  = 3'd1;
  localparam logic [2:0] REG_SHOW_ENDS        = 3'd2;
  localparam logic [2:0] REG_NUMBER_ALL       = 3'd3;
  localparam logic [2:0] REG_SQUEEZE_BLANK    = 3'd4;
  localparam logic [2:0] REG_SHOW_TABS        = 3'd5;

  localparam logic [7:0] CH_TAB    = 8'd9;
  localparam logic [7:0] CH_NL     = 8'd10;
  localparam logic [7:0] CH_US     = 8'd31;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_I      = 8'h49;
  localparam logic [7:0] CH_CARET  = 8'h5e;
  localparam logic [7:0] CH_DEL    = 8'd127;

  typedef struct packed {
    logic show_nonprinting;
    logic number_nonblank;
    logic show_ends;
    logic number_all;
    logic squeeze_blank;
    logic show_tabs;
  } cfg_t;

  // one classified byte waiting for the back end
  typedef struct packed {
    logic       num_en;
    logic       dollar_en;
    logic       caret_en;
    logic [7:0] data;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_START,
    ST_DIGIT,
    ST_TAB,
    ST_DOLLAR,
    ST_CARET,
    ST_DATA
  } st_t;

endpackage

/* rtl/tslf_front.sv */
// tslf_front: accepts input bytes, keeps history and line counter, classifies
// depends on tslf_pkg

module tslf_front #(
  parameter int NUMBER_DIGITS = tslf_pkg::DEF_NUMBER_DIGITS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  tslf_pkg::cfg_t               cfg,
  input  logic                         acc,
  input  logic [7:0]                   in_byte,
  input  logic                         file_start,
  output logic                         push,
  output tslf_pkg::cmd_t               push_cmd,
  output logic [4*NUMBER_DIGITS-1:0]   push_bcd
);
  import tslf_pkg::*;

  localparam int BW = 4 * NUMBER_DIGITS;
  localparam logic [BW-1:0] BCD_ONE = BW'(1);

  logic [7:0]    prev_byte_r, prev_byte_nxt;
  logic          prev_valid_r, prev_valid_nxt;
  logic [7:0]    prev2_byte_r, prev2_byte_nxt;
  logic [BW-1:0] bcd_r, bcd_nxt;

  logic [7:0]    pb;
  logic          pv;
  logic [7:0]    p2;
  logic [BW-1:0] bcd;
  logic [BW-1:0] bcd_inc;
  logic          all_nines;
  logic          carry;
  logic          ctrl, squeezed, at_start, differs, num_en;

  assign pb  = file_start ? 8'd0 : prev_byte_r;
  assign pv  = file_start ? 1'b0 : prev_valid_r;
  assign p2  = file_start ? 8'd0 : prev2_byte_r;
  assign bcd = file_start ? BCD_ONE : bcd_r;

  // decimal increment, holding at all nines
  always_comb begin
    bcd_inc   = bcd;
    carry     = 1'b1;
    all_nines = 1'b1;
    for (int i = 0; i < NUMBER_DIGITS; i++) begin
      if (bcd[4*i +: 4] != 4'd9) all_nines = 1'b0;
      if (carry) begin
        if (bcd[4*i +: 4] == 4'd9) begin
          bcd_inc[4*i +: 4] = 4'd0;
        end else begin
          bcd_inc[4*i +: 4] = bcd[4*i +: 4] + 4'd1;
          carry             = 1'b0;
        end
      end
    end
    if (all_nines) bcd_inc = bcd;
  end

  always_comb begin
    ctrl     = (in_byte < CH_TAB) || (in_byte > CH_NL && in_byte <= CH_US) ||
               (in_byte == CH_DEL);
    squeezed = cfg.squeeze_blank && in_byte == CH_NL && pv && pb == CH_NL && p2 == CH_NL;
    at_start = (pv && pb == CH_NL) || (bcd == BCD_ONE);
    differs  = !pv || (pb != in_byte);
    if (cfg.number_nonblank) begin
      num_en = at_start && differs && in_byte != CH_NL;
    end else begin
      num_en = cfg.number_all && at_start;
    end

    push               = acc && !squeezed;
    push_bcd           = bcd;
    push_cmd.num_en    = num_en;
    push_cmd.dollar_en = cfg.show_ends && in_byte == CH_NL;
    push_cmd.caret_en  = (cfg.show_nonprinting && ctrl) || (cfg.show_tabs && in_byte == CH_TAB);
    if (cfg.show_nonprinting && ctrl) begin
      push_cmd.data = {1'b0, ~in_byte[6], in_byte[5:0]};
    end else if (cfg.show_tabs && in_byte == CH_TAB) begin
      push_cmd.data = CH_I;
    end else begin
      push_cmd.data = in_byte;
    end

    prev_byte_nxt  = prev_byte_r;
    prev_valid_nxt = prev_valid_r;
    prev2_byte_nxt = prev2_byte_r;
    bcd_nxt        = bcd_r;
    if (acc) begin
      prev2_byte_nxt = pv ? pb : 8'd0;
      prev_byte_nxt  = in_byte;
      prev_valid_nxt = 1'b1;
      bcd_nxt        = (!squeezed && num_en) ? bcd_inc : bcd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_byte_r  <= 8'd0;
      prev_valid_r <= 1'b0;
      prev2_byte_r <= 8'd0;
      bcd_r        <= BCD_ONE;
    end else begin
      prev_byte_r  <= prev_byte_nxt;
      prev_valid_r <= prev_valid_nxt;
      prev2_byte_r <= prev2_byte_nxt;
      bcd_r        <= bcd_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_hist_shift: assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> prev_valid_r && prev_byte_r == $past(in_byte))
    else $error("history not updated on accepted byte");
`endif

endmodule

/* rtl/tslf_fifo.sv */
// tslf_fifo: short register queue between the front and back ends
// no dependencies

module tslf_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty,
  output logic             full
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;

  assign rdata = mem_r[rd_ptr_r];
  assign empty = (count_r == '0);
  assign full  = (count_r == CW'(DEPTH));

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    if (pop)  rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    if (push && !pop) count_nxt = count_r + CW'(1);
    if (pop && !push) count_nxt = count_r - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full))
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && empty))
    else $error("pop from empty queue");
`endif

endmodule

/* rtl/tslf_back.sv */
// tslf_back: expands queued commands into output bytes, one per cycle while out_tready allows
// depends on tslf_pkg

module tslf_back #(
  parameter int NUMBER_DIGITS = tslf_pkg::DEF_NUMBER_DIGITS
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       head_valid,
  input  tslf_pkg::cmd_t             head_cmd,
  input  logic [4*NUMBER_DIGITS-1:0] head_bcd,
  output logic                       pop,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [7:0]                 out_tdata,
  output logic                       out_tlast
);
  import tslf_pkg::*;

  localparam int DIGW = (NUMBER_DIGITS > 1) ? $clog2(NUMBER_DIGITS) : 1;
  localparam logic [DIGW-1:0] DIG_TOP = DIGW'(NUMBER_DIGITS - 1);

  st_t             st_r, st_nxt;
  logic [DIGW-1:0] dig_r, dig_nxt;
  logic            seen_r, seen_nxt;
  logic            out_tvalid_r, out_tvalid_nxt;
  logic [7:0]      out_tdata_r, out_tdata_nxt;
  logic            out_tlast_r, out_tlast_nxt;

  st_t             ph;
  st_t             after_tab;
  logic [DIGW-1:0] dig;
  logic            seen;
  logic [3:0]      d;
  logic            adv, fire;

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tlast  = out_tlast_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= ST_START;
      dig_r        <= '0;
      seen_r       <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      st_r         <= st_nxt;
      dig_r        <= dig_nxt;
      seen_r       <= seen_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_tdata_r <= out_tdata_nxt;
    out_tlast_r <= out_tlast_nxt;
  end

  always_comb begin
    adv  = !out_tvalid_r || out_tready;
    fire = adv && head_valid;

    if (head_cmd.dollar_en)     after_tab = ST_DOLLAR;
    else if (head_cmd.caret_en) after_tab = ST_CARET;
    else                        after_tab = ST_DATA;

    if (st_r == ST_START) begin
      ph   = head_cmd.num_en ? ST_DIGIT : after_tab;
      dig  = DIG_TOP;
      seen = 1'b0;
    end else begin
      ph   = st_r;
      dig  = dig_r;
      seen = seen_r;
    end
    d = head_bcd[4*dig +: 4];

    st_nxt         = st_r;
    dig_nxt        = dig_r;
    seen_nxt       = seen_r;
    pop            = 1'b0;
    out_tvalid_nxt = adv ? 1'b0 : out_tvalid_r;
    out_tdata_nxt  = out_tdata_r;
    out_tlast_nxt  = out_tlast_r;

    if (fire) begin
      out_tvalid_nxt = 1'b1;
      out_tlast_nxt  = 1'b0;
      unique case (ph)
        ST_DIGIT: begin
          out_tdata_nxt = (seen || d != 4'd0 || dig == '0) ? (CH_ZERO | {4'd0, d}) : CH_SPACE;
          seen_nxt      = seen || d != 4'd0;
          dig_nxt       = dig - DIGW'(1);
          st_nxt        = (dig == '0) ? ST_TAB : ST_DIGIT;
        end
        ST_TAB: begin
          out_tdata_nxt = CH_TAB;
          st_nxt        = after_tab;
        end
        ST_DOLLAR: begin
          out_tdata_nxt = CH_DOLLAR;
          st_nxt        = head_cmd.caret_en ? ST_CARET : ST_DATA;
        end
        ST_CARET: begin
          out_tdata_nxt = CH_CARET;
          st_nxt        = ST_DATA;
        end
        ST_DATA: begin
          out_tdata_nxt = head_cmd.data;
          out_tlast_nxt = 1'b1;
          pop           = 1'b1;
          st_nxt        = ST_START;
        end
        default: begin
          st_nxt = ST_START;
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_pop_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> out_tvalid_r && out_tlast_r)
    else $error("command retired without final byte");
  a_last_digit: assert property (@(posedge clk) disable iff (!rst_n)
    fire && ph == ST_DIGIT && dig == '0 |=> out_tdata_r != CH_SPACE)
    else $error("units digit printed as padding");
  a_mid_state: assert property (@(posedge clk) disable iff (!rst_n)
    st_r != ST_START |-> head_valid)
    else $error("command in progress without queue entry");
`endif

endmodule

/* rtl/text_stream_line_formatter_top.sv */
// an accepted byte passes the command queue and then the output register before it shows
// output: one byte per cycle while out_tready allows; each command gives one data byte,
// a numbered line start adds NUMBER_DIGITS digit bytes and a tab, and show_ends and caret escapes add a $ and a ^,
// all in the output sequencer; a small command queue lets input keep flowing while a prefix is being written
// reset (synchronous, rst_n low): config and state registers cleared, history empty, line counter one, queue empty
// text_stream_line_formatter_top: config registers, front, queue and back; depends on tslf_pkg

module text_stream_line_formatter_top #(
  parameter int NUMBER_DIGITS = tslf_pkg::DEF_NUMBER_DIGITS,
  parameter int QUEUE_DEPTH   = tslf_pkg::DEF_QUEUE_DEPTH
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [7:0]                  in_tdata,   // [7:0] in_byte
  input  logic                        in_tuser,   // [0] file_start
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [7:0]                  out_tdata,  // [7:0] out_byte
  output logic                        out_tlast,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [tslf_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [31:0]                 cfg_pwdata,
  output logic [31:0]                 cfg_prdata,
  output logic                        cfg_pready
);
  import tslf_pkg::*;

  localparam int BW = 4 * NUMBER_DIGITS;
  localparam int QW = $bits(cmd_t) + BW;

  cfg_t          cfg_r, cfg_nxt;
  logic [2:0]    reg_idx;
  logic          cfg_wr;
  logic          acc, push, pop, q_empty, q_full;
  cmd_t          push_cmd, head_cmd;
  logic [BW-1:0] push_bcd, head_bcd;

  assign cfg_pready = 1'b1;
  assign reg_idx    = cfg_paddr[4:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr) begin
      unique case (reg_idx)
        REG_SHOW_NONPRINTING: cfg_nxt.show_nonprinting = cfg_pwdata[0];
        REG_NUMBER_NONBLANK:  cfg_nxt.number_nonblank  = cfg_pwdata[0];
        REG_SHOW_ENDS:        cfg_nxt.show_ends        = cfg_pwdata[0];
        REG_NUMBER_ALL:       cfg_nxt.number_all       = cfg_pwdata[0];
        REG_SQUEEZE_BLANK:    cfg_nxt.squeeze_blank    = cfg_pwdata[0];
        REG_SHOW_TABS:        cfg_nxt.show_tabs        = cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_SHOW_NONPRINTING: cfg_prdata = {31'd0, cfg_r.show_nonprinting};
      REG_NUMBER_NONBLANK:  cfg_prdata = {31'd0, cfg_r.number_nonblank};
      REG_SHOW_ENDS:        cfg_prdata = {31'd0, cfg_r.show_ends};
      REG_NUMBER_ALL:       cfg_prdata = {31'd0, cfg_r.number_all};
      REG_SQUEEZE_BLANK:    cfg_prdata = {31'd0, cfg_r.squeeze_blank};
      REG_SHOW_TABS:        cfg_prdata = {31'd0, cfg_r.show_tabs};
      default:              cfg_prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign in_tready = !q_full;
  assign acc       = in_tvalid && in_tready;

  tslf_front #(
    .NUMBER_DIGITS(NUMBER_DIGITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .acc        (acc),
    .in_byte    (in_tdata),
    .file_start (in_tuser),
    .push       (push),
    .push_cmd   (push_cmd),
    .push_bcd   (push_bcd)
  );

  tslf_fifo #(
    .WIDTH(QW),
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata ({push_bcd, push_cmd}),
    .pop   (pop),
    .rdata ({head_bcd, head_cmd}),
    .empty (q_empty),
    .full  (q_full)
  );

  tslf_back #(
    .NUMBER_DIGITS(NUMBER_DIGITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (!q_empty),
    .head_cmd   (head_cmd),
    .head_bcd   (head_bcd),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule
